// ===== hw/rtl/tsr_pkg.sv =====
`timescale 1ns / 1ps

package tsr_pkg;

    localparam int CHARS_PER_ROW      = 64;
    localparam int CELL_HEIGHT        = 12;
    localparam int CELL_WIDTH         = 6;
    localparam int FONT_ROWS_PER_CODE = 16;
    localparam int TEXT_ROWS          = 16;

    localparam int VRAM_DEPTH = 1024;
    localparam int FONT_DEPTH = 2048;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int FONT_AW    = $clog2(FONT_DEPTH);

    localparam int MAX_BYTES   = 48;
    localparam int RAW_BYTES   = (CHARS_PER_ROW * CELL_WIDTH) / 8;
    localparam int TOTAL_BYTES = (RAW_BYTES > MAX_BYTES) ? MAX_BYTES : RAW_BYTES;
    localparam int SCREEN_LINES = TEXT_ROWS * CELL_HEIGHT;

    localparam int COL_W   = $clog2(CHARS_PER_ROW + 1);
    localparam int TROW_W  = $clog2(TEXT_ROWS + 1);
    localparam int ROW_W   = $clog2(FONT_ROWS_PER_CODE);
    localparam int CNT_W   = 6;
    localparam int NBITS_W = 4;
    localparam int CMP_W   = 10;

    localparam int DIV_SH    = 16;
    localparam int DIV_RECIP = ((2 ** DIV_SH) + CELL_HEIGHT - 1) / CELL_HEIGHT;
    localparam int PROD_W    = 8 + $clog2(DIV_RECIP + 1);

    localparam logic [7:0] GFX_MASK  = 8'h80;
    localparam logic [7:0] GFX_LEFT  = 8'he0;
    localparam logic [7:0] GFX_RIGHT = 8'h1c;

    typedef enum logic [1:0] {
        REQ_VRAM_WR = 2'd0,
        REQ_FONT_WR = 2'd1,
        REQ_RENDER  = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic            strobe;
        logic [7:0]      pixels;
        logic [CNT_W-1:0] byte_index;
        logic            last;
    } t_px_res;

endpackage

// ===== hw/rtl/text_semigraphics_scanline_render.sv =====
`timescale 1ns / 1ps
// write items: busy stays low, no result
// render item (line below SCREEN_LINES): busy while it runs, one column per cycle, each cell
//   going through the video ram read followed by the font store read
// first byte strobes after ST_DIV, ST_REM and two cells' ram reads, then mostly one byte a cycle
// results cannot be stalled: each byte is shown for exactly one cycle
// synchronous active-low reset clears control; memory contents are kept and undefined at start

module text_semigraphics_scanline_render (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [10:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_line_index,
    output logic        o_strobe,
    output logic [7:0]  o_pixels,
    output logic [5:0]  o_byte_index,
    output logic        o_last
);

    import tsr_pkg::*;

    t_state r_state, n_state;

    logic [7:0]         r_line, n_line;
    logic [TROW_W-1:0]  r_trow, n_trow;
    logic [ROW_W-1:0]   r_rowin, n_rowin;
    logic [VRAM_AW-1:0] r_base, n_base;
    logic [COL_W-1:0]   r_col, n_col;
    logic               r_s1_valid, n_s1_valid;
    logic               r_s2_valid;
    logic [7:0]         r_s2_code;

    logic               accept;
    logic               issue;
    logic               issue_done;
    logic               pk_clr;
    logic               pk_full;
    logic [PROD_W-1:0]  prod;
    logic [VRAM_AW-1:0] vram_raddr;
    logic [FONT_AW-1:0] font_raddr;
    logic [7:0]         vram_q;
    logic [7:0]         font_q;
    logic [7:0]         gfx;
    logic [7:0]         cell8;
    logic [CELL_WIDTH-1:0] cell_px;
    t_px_res            res;

    assign accept = start && !busy;

    tsr_ram #(.DEPTH(VRAM_DEPTH), .WIDTH(8)) u_vram (
        .i_clk   (i_clk),
        .i_we    (accept && (t_req'(i_req_type) == REQ_VRAM_WR)),
        .i_waddr (i_address[VRAM_AW-1:0]),
        .i_wdata (i_data),
        .i_raddr (vram_raddr),
        .o_rdata (vram_q)
    );

    tsr_ram #(.DEPTH(FONT_DEPTH), .WIDTH(8)) u_font (
        .i_clk   (i_clk),
        .i_we    (accept && (t_req'(i_req_type) == REQ_FONT_WR)),
        .i_waddr (i_address[FONT_AW-1:0]),
        .i_wdata (i_data),
        .i_raddr (font_raddr),
        .o_rdata (font_q)
    );

    assign issue_done = (r_col == COL_W'(CHARS_PER_ROW)) || pk_full;
    assign issue      = (r_state == ST_RUN) && !issue_done;
    assign vram_raddr = VRAM_AW'(32'(r_base) + 32'(r_col));
    assign font_raddr = FONT_AW'(32'(vram_q[6:0]) * FONT_ROWS_PER_CODE + 32'(r_rowin));
    assign prod       = PROD_W'(32'(r_line) * DIV_RECIP);

    always_comb begin
        n_state    = r_state;
        n_line     = r_line;
        n_trow     = r_trow;
        n_rowin    = r_rowin;
        n_base     = r_base;
        n_col      = r_col;
        n_s1_valid = issue;
        pk_clr     = 1'b0;
        busy       = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                n_line = i_line_index;
                if (accept && (t_req'(i_req_type) == REQ_RENDER) &&
                    ({2'b00, i_line_index} < CMP_W'(SCREEN_LINES))) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_trow  = TROW_W'(prod >> DIV_SH);
                n_state = ST_REM;
            end
            ST_REM: begin
                n_rowin = ROW_W'(r_line - 8'(32'(r_trow) * CELL_HEIGHT));
                n_base  = VRAM_AW'(32'(r_trow) * CHARS_PER_ROW);
                n_col   = '0;
                pk_clr  = 1'b1;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (issue) begin
                    n_col = r_col + COL_W'(1);
                end
                if (issue_done && !r_s1_valid && !r_s2_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line    <= n_line;
        r_trow    <= n_trow;
        r_rowin   <= n_rowin;
        r_base    <= n_base;
        r_s2_code <= vram_q;
    end

    // 2x3 block graphics: row band picks two code bits
    always_comb begin
        gfx = 8'h00;
        case (r_rowin[ROW_W-1:ROW_W-2])
            2'd0: begin
                if (r_s2_code[0]) gfx = gfx | GFX_LEFT;
                if (r_s2_code[1]) gfx = gfx | GFX_RIGHT;
            end
            2'd1: begin
                if (r_s2_code[2]) gfx = gfx | GFX_LEFT;
                if (r_s2_code[3]) gfx = gfx | GFX_RIGHT;
            end
            2'd2: begin
                if (r_s2_code[4]) gfx = gfx | GFX_LEFT;
                if (r_s2_code[5]) gfx = gfx | GFX_RIGHT;
            end
            2'd3: begin
                if (r_s2_code[6]) gfx = gfx | GFX_LEFT;
                if (r_s2_code[7]) gfx = gfx | GFX_RIGHT;
            end
            default: begin
                gfx = 8'h00;
            end
        endcase
        cell8   = ((r_s2_code & GFX_MASK) != 8'h00) ? gfx : font_q;
        cell_px = CELL_WIDTH'(cell8 >> (8 - CELL_WIDTH));
    end

    tsr_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (pk_clr),
        .i_valid (r_s2_valid),
        .i_bits  (cell_px),
        .o_full  (pk_full),
        .o_res   (res)
    );

    assign o_strobe     = res.strobe;
    assign o_pixels     = res.pixels;
    assign o_byte_index = res.byte_index;
    assign o_last       = res.last;

endmodule

// ===== hw/rtl/tsr_ram.sv =====
`timescale 1ns / 1ps

module tsr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tsr_packer.sv =====
`timescale 1ns / 1ps

module tsr_packer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_clr,
    input  logic                            i_valid,
    input  logic [tsr_pkg::CELL_WIDTH-1:0] i_bits,
    output logic                            o_full,
    output tsr_pkg::t_px_res                o_res
);

    import tsr_pkg::*;

    localparam int CAT_W = CELL_WIDTH + 7;

    logic [6:0]         r_acc, n_acc;
    logic [NBITS_W-1:0] r_nbits, n_nbits;
    logic [CNT_W-1:0]   r_count, n_count;
    t_px_res            r_res, n_res;

    logic [CAT_W-1:0]   cat;
    logic [NBITS_W-1:0] sum;
    logic [NBITS_W-1:0] rem;
    logic [CAT_W-1:0]   keep_mask;
    logic               full;

    assign full = (r_count == CNT_W'(TOTAL_BYTES));

    always_comb begin
        cat       = {r_acc, i_bits};
        sum       = r_nbits + NBITS_W'(CELL_WIDTH);
        rem       = sum - NBITS_W'(8);
        keep_mask = (CAT_W'(1) << rem) - CAT_W'(1);
        n_acc     = r_acc;
        n_nbits   = r_nbits;
        n_count   = r_count;
        n_res     = '0;
        n_res.pixels     = r_res.pixels;
        n_res.byte_index = r_res.byte_index;
        n_res.last       = r_res.last;
        if (i_clr) begin
            n_acc   = '0;
            n_nbits = '0;
            n_count = '0;
        end else if (i_valid && !full) begin
            if (sum >= NBITS_W'(8)) begin
                n_res.strobe     = 1'b1;
                n_res.pixels     = 8'(cat >> rem);
                n_res.byte_index = r_count;
                n_res.last       = (r_count == CNT_W'(TOTAL_BYTES - 1));
                n_acc            = 7'(cat & keep_mask);
                n_nbits          = rem;
                n_count          = r_count + CNT_W'(1);
            end else begin
                n_acc   = 7'(cat);
                n_nbits = sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc            <= n_acc;
        r_res.pixels     <= n_res.pixels;
        r_res.byte_index <= n_res.byte_index;
        r_res.last       <= n_res.last;
        if (!i_rst_n) begin
            r_nbits    <= '0;
            r_count    <= '0;
            r_res.strobe <= 1'b0;
        end else begin
            r_nbits    <= n_nbits;
            r_count    <= n_count;
            r_res.strobe <= n_res.strobe;
        end
    end

    assign o_full = full;
    assign o_res  = r_res;

endmodule

// ===== tb/sv/scanline_check.sv =====
`timescale 1ns / 1ps

module scanline_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_req_type,
    input  logic [10:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_line_index,
    input  logic        i_strobe,
    input  logic [7:0]  i_pixels,
    input  logic [5:0]  i_byte_index,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    import tsr_pkg::*;

    localparam int ROWS_PER_BAND = 4;

    typedef struct {
        logic [7:0] pix;
        logic [5:0] idx;
        logic       last;
    } t_px_byte;

    t_px_byte   line_bytes_q[$];
    logic [7:0] vram_img [VRAM_DEPTH];
    logic [7:0] font_img [FONT_DEPTH];
    int         fails = 0;

    // one row of one cell, already cut down to the cell width
    function automatic logic [7:0] cell_row(input logic [7:0] code, input int row);
        logic [7:0] bits;
        logic [1:0] sel;
        int         sh;
        int         fa;
        if ((code & GFX_MASK) == 8'h00) begin
            fa   = code * FONT_ROWS_PER_CODE + row;
            bits = font_img[fa % FONT_DEPTH];
        end else begin
            sh   = (row / ROWS_PER_BAND) * 2;
            sel  = (sh < 8) ? code[sh +: 2] : 2'b00;
            bits = 8'h00;
            if (sel[0]) bits |= GFX_LEFT;
            if (sel[1]) bits |= GFX_RIGHT;
        end
        return bits >> (8 - CELL_WIDTH);
    endfunction

    task automatic predict_scanline(input logic [7:0] line);
        int unsigned text_row;
        int unsigned row;
        int unsigned base;
        int unsigned acc;
        int unsigned nbits;
        int unsigned count;
        t_px_byte    pb;
        text_row = line / CELL_HEIGHT;
        row      = line % CELL_HEIGHT;
        base     = text_row * CHARS_PER_ROW;
        acc      = 0;
        nbits    = 0;
        count    = 0;
        for (int col = 0; col < CHARS_PER_ROW && count < TOTAL_BYTES; col++) begin
            acc   = (acc << CELL_WIDTH) | cell_row(vram_img[(base + col) % VRAM_DEPTH], row);
            nbits += CELL_WIDTH;
            if (nbits >= 8) begin
                nbits   -= 8;
                pb.pix  = 8'(acc >> nbits);
                pb.idx  = 6'(count);
                pb.last = (count + 1 == TOTAL_BYTES);
                line_bytes_q.push_back(pb);
                count++;
                acc &= (1 << nbits) - 1;
            end
        end
    endtask

    task automatic check_byte();
        t_px_byte exp_b;
        if (line_bytes_q.size() == 0) begin
            $display("%0t: unexpected byte %02h index %0d last %0b",
                     $time, i_pixels, i_byte_index, i_last);
            fails++;
        end else begin
            exp_b = line_bytes_q.pop_front();
            if (i_pixels !== exp_b.pix) begin
                $display("%0t: pixels expected %02h got %02h",
                         $time, exp_b.pix, i_pixels);
                fails++;
            end
            if (i_byte_index !== exp_b.idx) begin
                $display("%0t: byte_index expected %0d got %0d",
                         $time, exp_b.idx, i_byte_index);
                fails++;
            end
            if (i_last !== exp_b.last) begin
                $display("%0t: last expected %0b got %0b", $time, exp_b.last, i_last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_strobe) check_byte();
            if (i_start && !i_busy) begin
                case (t_req'(i_req_type))
                    REQ_VRAM_WR: vram_img[i_address[VRAM_AW-1:0]] = i_data;
                    REQ_FONT_WR: font_img[i_address[FONT_AW-1:0]] = i_data;
                    REQ_RENDER: begin
                        if (i_line_index < SCREEN_LINES) predict_scanline(i_line_index);
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= line_bytes_q.size();
    end

endmodule

// ===== tb/sv/tb_text_semigraphics_scanline_render.sv =====
`timescale 1ns / 1ps

module tb_text_semigraphics_scanline_render;
    import tsr_pkg::*;

    localparam logic [7:0] FONT_CODES [4] = '{8'h00, 8'h01, 8'h41, 8'h7f};

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [10:0] i_address;
    logic [7:0]  i_data;
    logic [7:0]  i_line_index;
    logic        o_strobe;
    logic [7:0]  o_pixels;
    logic [5:0]  o_byte_index;
    logic        o_last;
    int          fail_count;
    int          pending;
    int          burst_left;

    text_semigraphics_scanline_render DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_data       (i_data),
        .i_line_index (i_line_index),
        .o_strobe     (o_strobe),
        .o_pixels     (o_pixels),
        .o_byte_index (o_byte_index),
        .o_last       (o_last)
    );

    scanline_check u_scanline_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_data       (i_data),
        .i_line_index (i_line_index),
        .i_strobe     (o_strobe),
        .i_pixels     (o_pixels),
        .i_byte_index (o_byte_index),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("tb_text_semigraphics_scanline_render NOT OK");
        $finish;
    end

    // a loaded font code or a block graphics code
    function automatic logic [7:0] pick_code();
        logic [7:0] code;
        if ($urandom_range(0, 1) == 0) begin
            code = FONT_CODES[$urandom_range(0, 3)];
        end else begin
            code = GFX_MASK | 8'($urandom);
        end
        return code;
    endfunction

    // an entry of the first or the last text row, upper address bit random
    function automatic logic [10:0] pick_vram_addr();
        logic [10:0] a;
        a = 11'($urandom_range(0, CHARS_PER_ROW - 1));
        if ($urandom_range(0, 1) == 1) a = a + 11'((TEXT_ROWS - 1) * CHARS_PER_ROW);
        a[VRAM_AW] = 1'($urandom);
        return a;
    endfunction

    // a scanline of the first or the last text row
    function automatic logic [7:0] pick_line();
        logic [7:0] line;
        if ($urandom_range(0, 1) == 0) begin
            line = 8'($urandom_range(0, CELL_HEIGHT - 1));
        end else begin
            line = 8'($urandom_range(SCREEN_LINES - CELL_HEIGHT, SCREEN_LINES - 1));
        end
        return line;
    endfunction

    // end of a burst: drop start and wiggle the fields for a while
    task automatic pace();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 80) : $urandom_range(1, 6);
            repeat (gap) begin
                i_req_type   <= 2'($urandom);
                i_address    <= 11'($urandom);
                i_data       <= 8'($urandom);
                i_line_index <= 8'($urandom);
                @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_item(input t_req req, input logic [10:0] addr,
                             input logic [7:0] dat, input logic [7:0] line);
        start        <= 1'b1;
        i_req_type   <= req;
        i_address    <= addr;
        i_data       <= dat;
        i_line_index <= line;
        do @(posedge i_clk); while (busy);
        pace();
    endtask

    initial begin
        int r;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_req_type   = 2'b00;
        i_address    = 11'h000;
        i_data       = 8'h00;
        i_line_index = 8'h00;
        burst_left   = $urandom_range(1, 12);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load the font rows of a few codes and the first and last text rows;
        // renders stay on those rows so that no unwritten entry is read
        for (int c = 0; c < 4; c++)
            for (int row = 0; row < CELL_HEIGHT; row++)
                send_item(REQ_FONT_WR, 11'(FONT_CODES[c] * FONT_ROWS_PER_CODE + row),
                          8'($urandom), 8'($urandom));
        for (int col = 0; col < CHARS_PER_ROW; col++) begin
            send_item(REQ_VRAM_WR, 11'(col), pick_code(), 8'($urandom));
            send_item(REQ_VRAM_WR, 11'((TEXT_ROWS - 1) * CHARS_PER_ROW + col),
                      pick_code(), 8'($urandom));
        end

        // directed
        send_item(REQ_VRAM_WR, 11'h000, 8'h00, 8'h00);
        send_item(REQ_VRAM_WR, 11'h001, 8'hff, 8'hff);
        send_item(REQ_VRAM_WR, 11'h002, 8'h80, 8'h00);
        send_item(REQ_VRAM_WR, 11'h003, 8'h7f, 8'hff);
        send_item(REQ_VRAM_WR, 11'h7ff, 8'hc9, 8'h00);
        send_item(REQ_FONT_WR, 11'h000, 8'hff, 8'h00);
        send_item(REQ_FONT_WR, 11'h7f0, 8'h03, 8'hff);
        send_item(REQ_FONT_WR, 11'h7fb, 8'hfc, 8'h00);
        send_item(REQ_FONT_WR, 11'h7ff, 8'h00, 8'hff);
        send_item(REQ_RENDER, 11'h000, 8'h00, 8'd0);
        send_item(REQ_RENDER, 11'h7ff, 8'hff, 8'd4);
        send_item(REQ_RENDER, 11'h000, 8'h00, 8'd8);
        send_item(REQ_RENDER, 11'h7ff, 8'hff, 8'd11);
        send_item(REQ_RENDER, 11'h000, 8'h00, 8'(SCREEN_LINES - 1));
        send_item(REQ_RENDER, 11'h7ff, 8'hff, 8'(SCREEN_LINES));
        send_item(REQ_RENDER, 11'h000, 8'h00, 8'hff);
        send_item(REQ_NONE, 11'h7ff, 8'hff, 8'hff);
        send_item(REQ_VRAM_WR, 11'h400, 8'haa, 8'h00);
        send_item(REQ_VRAM_WR, 11'h43f, 8'h41, 8'h00);
        send_item(REQ_RENDER, 11'h000, 8'h00, 8'd1);
        send_item(REQ_RENDER, 11'h000, 8'h00, 8'd10);

        // random
        for (int n = 0; n < 75; n++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_item(REQ_RENDER, 11'($urandom), 8'($urandom), pick_line());
            end else if (r < 42) begin
                send_item(REQ_RENDER, 11'($urandom), 8'($urandom),
                          8'($urandom_range(SCREEN_LINES, 255)));
            end else if (r < 46) begin
                send_item(REQ_NONE, 11'($urandom), 8'($urandom), 8'($urandom));
            end else if (r < 76) begin
                send_item(REQ_VRAM_WR, pick_vram_addr(), pick_code(), 8'($urandom));
            end else begin
                send_item(REQ_FONT_WR, 11'($urandom), 8'($urandom), 8'($urandom));
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_text_semigraphics_scanline_render OK");
        end else begin
            $display("tb_text_semigraphics_scanline_render NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_ram.sv
hw/rtl/tsr_packer.sv
hw/rtl/text_semigraphics_scanline_render.sv
tb/sv/scanline_check.sv
tb/sv/tb_text_semigraphics_scanline_render.sv
